>>> sv/ttmv_pkg.sv
package ttmv_pkg;

	localparam int SLOTS   = 64;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int ID_BITS = 32;

	typedef enum logic [1:0] {
		FN_BEGIN  = 2'd0,
		FN_COMMIT = 2'd1,
		FN_ABORT  = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		SLOT_ACTIVE    = 2'd0,
		SLOT_COMMITTED = 2'd1,
		SLOT_ABORTED   = 2'd2
	} slot_st_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		slot_st_t           st;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} fsm_t;

endpackage

>>> sv/transaction_table_mvcc_visibility.sv
// Channel  Dir  Signals                         Contents
// s_*      in   s_tvalid s_tready s_tdata s_tuser  one request item (op in tuser)
// m_*      out  m_tvalid m_tready m_tdata           one result item per request
//
// One item at a time. The slot table sits in one synchronous RAM
// (one read, one write port, registered read) walked one slot a cycle.
// Begin/commit/abort stop at the first hit and walk every slot when nothing
// matches. A query walks all SLOTS slots, looking for the creator and the
// deleter in the same pass; a query rejected by the deleted flag or by
// creator_id > txn_id skips the walk and goes straight to the result.
// Reset: per-slot valid flops clear at once, so an unwritten slot reads as
// id 0, aborted; no clearing pass. next_id resets to 1.
// Stalls: a finished result waits in the output register; the next item is
// accepted while it waits, and a later result waits in RESP until it drains.
module transaction_table_mvcc_visibility
	import ttmv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] txn_id, [32] tuple_deleted, [64:33] creator_id, [96:65] deleter_id,
	// [103:97] zero
	input  logic [103:0] s_tdata,
	// [1:0] func
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] status, [32:1] new_id, [33] visible, [39:34] zero
	output logic [39:0]  m_tdata
);

	fsm_t               state_q;
	func_t              op_q;
	logic [ID_BITS-1:0] me_q, cre_q, del_q, next_id_q;

	// table storage
	slot_t              mem [SLOTS];
	logic [SLOTS-1:0]   valid_q;

	// scan pipeline
	logic [IDX_W-1:0]   rd_idx_q, idx_s1;
	logic               issue_q, pend_s1, vld_s1;
	slot_t              rd_data_s1;

	// query match tracking
	logic               cfound_q, dfound_q;
	slot_st_t           cst_q, dst_q;

	// result holding
	logic               res_status_q, res_vis_q;
	logic [ID_BITS-1:0] res_id_q;

	// input field unpack
	func_t              in_func;
	logic [ID_BITS-1:0] in_me, in_cre, in_del;
	logic               in_deleted, accept, quick_rej;

	assign in_func    = func_t'(s_tuser);
	assign in_me      = s_tdata[31:0];
	assign in_deleted = s_tdata[32];
	assign in_cre     = s_tdata[64:33];
	assign in_del     = s_tdata[96:65];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign quick_rej = (in_func == FN_QUERY) && (in_deleted || (in_cre > in_me));

	// effective entry seen by the scan; unwritten slots read as id 0, aborted
	logic [ID_BITS-1:0] eid;
	slot_st_t           est;
	logic               last, cmatch, dmatch;

	assign eid    = vld_s1 ? rd_data_s1.id : '0;
	assign est    = vld_s1 ? rd_data_s1.st : SLOT_ABORTED;
	assign last   = (idx_s1 == IDX_W'(SLOTS - 1));
	assign cmatch = (eid == cre_q);
	assign dmatch = (eid == del_q);

	// per-entry decision
	logic               done, mem_we, r_status, r_vis, bump_id;
	logic               cf, df, rule3, rule4;
	slot_st_t           cst, dst;
	slot_t              wr_data;
	logic [ID_BITS-1:0] r_id;

	always_comb begin
		done     = 1'b0;
		mem_we   = 1'b0;
		bump_id  = 1'b0;
		wr_data  = '{id: eid, st: est};
		r_status = 1'b0;
		r_id     = '0;
		r_vis    = 1'b0;
		cf       = cfound_q | cmatch;
		df       = dfound_q | dmatch;
		cst      = cfound_q ? cst_q : est;
		dst      = dfound_q ? dst_q : est;
		rule3    = cf && (cst != SLOT_COMMITTED) && (cre_q != me_q);
		rule4    = (del_q != '0) && (del_q <= me_q)
			&& (!df || (del_q == me_q) || (dst == SLOT_COMMITTED));
		if (state_q == ST_SCAN && pend_s1) begin
			case (op_q)
				FN_BEGIN: begin
					if (est != SLOT_ACTIVE) begin
						done    = 1'b1;
						mem_we  = 1'b1;
						bump_id = 1'b1;
						wr_data = '{id: next_id_q, st: SLOT_ACTIVE};
						r_id    = next_id_q;
					end else if (last) begin
						done     = 1'b1;
						r_status = 1'b1;
					end
				end
				FN_COMMIT, FN_ABORT: begin
					if (eid == me_q) begin
						done = 1'b1;
						if (est == SLOT_ACTIVE) begin
							mem_we  = 1'b1;
							wr_data = '{id: eid,
								st: (op_q == FN_COMMIT) ? SLOT_COMMITTED : SLOT_ABORTED};
						end else begin
							r_status = 1'b1;
						end
					end else if (last) begin
						done     = 1'b1;
						r_status = 1'b1;
					end
				end
				default: begin
					if (last) begin
						done  = 1'b1;
						r_vis = !rule3 && !rule4;
					end
				end
			endcase
		end
	end

	// RAM: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_s1] <= wr_data;
		end
		if (state_q == ST_SCAN && issue_q) begin
			rd_data_s1 <= mem[rd_idx_q];
			vld_s1     <= valid_q[rd_idx_q];
			idx_s1     <= rd_idx_q;
		end
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			next_id_q <= ID_BITS'(1);
			issue_q   <= 1'b0;
			pend_s1   <= 1'b0;
			rd_idx_q  <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			// RESP reloads the output on its own when it drains
			if (m_tvalid && m_tready && state_q != ST_RESP) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						rd_idx_q <= '0;
						issue_q  <= 1'b1;
						state_q  <= quick_rej ? ST_RESP : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (mem_we) begin
						valid_q[idx_s1] <= 1'b1;
					end
					if (bump_id) begin
						next_id_q <= (next_id_q == '1) ? ID_BITS'(1) : next_id_q + 1'b1;
					end
					if (done) begin
						issue_q <= 1'b0;
						pend_s1 <= 1'b0;
						state_q <= ST_RESP;
					end else begin
						pend_s1 <= issue_q;
						if (issue_q && rd_idx_q == IDX_W'(SLOTS - 1)) begin
							issue_q <= 1'b0;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= in_func;
			me_q         <= in_me;
			cre_q        <= in_cre;
			del_q        <= in_del;
			cfound_q     <= 1'b0;
			dfound_q     <= 1'b0;
			res_status_q <= 1'b0;
			res_id_q     <= '0;
			res_vis_q    <= 1'b0;
		end
		if (state_q == ST_SCAN && pend_s1) begin
			if (!cfound_q && cmatch) begin
				cfound_q <= 1'b1;
				cst_q    <= est;
			end
			if (!dfound_q && dmatch) begin
				dfound_q <= 1'b1;
				dst_q    <= est;
			end
		end
		if (done) begin
			res_status_q <= r_status;
			res_id_q     <= r_id;
			res_vis_q    <= r_vis;
		end
		if (state_q == ST_RESP && out_free) begin
			m_tdata <= {6'd0, res_vis_q, res_id_q, res_status_q};
		end
	end

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_RESP))
		else $error("result raised outside RESP");

	a_next_id_nz: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("id counter reached zero");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN || state_q == ST_RESP))
		else $error("accepted item did not start");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (pend_s1 && (op_q != FN_QUERY)))
		else $error("table write without a pending entry");

endmodule
